// ===== sv/assert_macros.svh =====
// Assertion macros shared by the supervisor RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/cds_pkg.sv =====
// Types and constants for the cycle deadline supervisor.
// No dependencies; used by the channel interfaces and all modules.
package cds_pkg;

  localparam int SecW  = 31;
  localparam int NsecW = 30;
  localparam int TimeW = 32;
  localparam int CntW  = 32;
  localparam int ActW  = 2;
  localparam int CfgW  = 31;

  typedef logic [SecW-1:0]  sec_t;
  typedef logic [NsecW-1:0] nsec_t;
  typedef logic [TimeW-1:0] abs_sec_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [ActW-1:0]  act_t;
  typedef logic [CfgW-1:0]  cfg_data_t;

  localparam logic [NsecW:0] NsPerSec    = 31'd1000000000;
  localparam logic [NsecW:0] TwoNsPerSec = 31'd2000000000;
  localparam sec_t           SecMax      = 31'h7FFF_FFFF;
  localparam nsec_t          NsecMax     = 30'd999999999;

  typedef enum logic [1:0] {
    REG_LIMIT_SEC  = 2'd0,
    REG_LIMIT_NSEC = 2'd1,
    REG_ACTION     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    abs_sec_t sec;
    nsec_t    nsec;
  } stamp_t;

  typedef struct packed {
    sec_t     start_sec;
    nsec_t    start_nsec;
    sec_t     stop_sec;
    nsec_t    stop_nsec;
    abs_sec_t now_sec;
    nsec_t    now_nsec;
  } report_t;

  typedef struct packed {
    act_t   action;
    logic   overran;
    logic   delayed_flag;
    logic   timely_flag;
    cnt_t   delays_seen;
    cnt_t   cycles_seen;
    stamp_t delayed_at;
    stamp_t timely_at;
    stamp_t last_overrun;
  } result_t;

endpackage

// ===== sv/cds_if.sv =====
// Valid/ready channel interfaces: cycle reports in, supervision results out.
// Depends on cds_pkg for field types.
interface cds_report_if;
  logic              valid;
  logic              ready;
  cds_pkg::sec_t     start_sec;
  cds_pkg::nsec_t    start_nsec;
  cds_pkg::sec_t     stop_sec;
  cds_pkg::nsec_t    stop_nsec;
  cds_pkg::abs_sec_t now_sec;
  cds_pkg::nsec_t    now_nsec;

  modport source (output valid, start_sec, start_nsec, stop_sec, stop_nsec, now_sec,
                  now_nsec, input ready);
  modport sink (input valid, start_sec, start_nsec, stop_sec, stop_nsec, now_sec,
                now_nsec, output ready);
endinterface

interface cds_result_if;
  logic              valid;
  logic              ready;
  cds_pkg::act_t     action;
  logic              overran;
  logic              delayed_flag;
  logic              timely_flag;
  cds_pkg::cnt_t     delays_seen;
  cds_pkg::cnt_t     cycles_seen;
  cds_pkg::abs_sec_t delayed_at_sec;
  cds_pkg::nsec_t    delayed_at_nsec;
  cds_pkg::abs_sec_t timely_at_sec;
  cds_pkg::nsec_t    timely_at_nsec;
  cds_pkg::abs_sec_t last_overrun_sec;
  cds_pkg::nsec_t    last_overrun_nsec;

  modport source (output valid, action, overran, delayed_flag, timely_flag, delays_seen,
                  cycles_seen, delayed_at_sec, delayed_at_nsec, timely_at_sec,
                  timely_at_nsec, last_overrun_sec, last_overrun_nsec, input ready);
  modport sink (input valid, action, overran, delayed_flag, timely_flag, delays_seen,
                cycles_seen, delayed_at_sec, delayed_at_nsec, timely_at_sec,
                timely_at_nsec, last_overrun_sec, last_overrun_nsec, output ready);
endinterface

// ===== sv/cds_deadline_calc.sv =====
// Next deadline: start offset plus allowed delay, normalized and saturated.
// Depends on cds_pkg.
module cds_deadline_calc (
  input  cds_pkg::sec_t  start_sec,
  input  cds_pkg::nsec_t start_nsec,
  input  cds_pkg::sec_t  limit_sec,
  input  cds_pkg::nsec_t limit_nsec,
  output cds_pkg::sec_t  deadline_sec,
  output cds_pkg::nsec_t deadline_nsec
);
  import cds_pkg::*;

  logic [NsecW:0]  ns_sum;
  logic [NsecW:0]  ns_rem;
  logic [1:0]      carry;
  logic [SecW+1:0] sec_sum;

  // Sum of two 30-bit fields stays below 2^31, so at most two carries.
  assign ns_sum = {1'b0, start_nsec} + {1'b0, limit_nsec};

  always_comb begin
    priority if (ns_sum >= TwoNsPerSec) begin
      carry  = 2'd2;
      ns_rem = ns_sum - TwoNsPerSec;
    end else if (ns_sum >= NsPerSec) begin
      carry  = 2'd1;
      ns_rem = ns_sum - NsPerSec;
    end else begin
      carry  = 2'd0;
      ns_rem = ns_sum;
    end
  end

  assign sec_sum = {2'b00, start_sec} + {2'b00, limit_sec} + {{SecW{1'b0}}, carry};

  always_comb begin
    if (sec_sum > {2'b00, SecMax}) begin
      deadline_sec  = SecMax;
      deadline_nsec = NsecMax;
    end else begin
      deadline_sec  = sec_sum[SecW-1:0];
      deadline_nsec = ns_rem[NsecW-1:0];
    end
  end
endmodule

// ===== sv/cds_monitor.sv =====
// Supervision state: deadline, flags, counters and timestamps, plus the
// per-result action bits. Depends on cds_pkg and cds_deadline_calc.
module cds_monitor (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  cds_pkg::report_t item,
  input  cds_pkg::sec_t    limit_sec,
  input  cds_pkg::nsec_t   limit_nsec,
  input  cds_pkg::act_t    overrun_action,
  output cds_pkg::result_t res
);
  import cds_pkg::*;

  sec_t   deadline_sec, deadline_sec_next;
  nsec_t  deadline_nsec, deadline_nsec_next;
  logic   delayed, delayed_next;
  logic   timely, timely_next;
  cnt_t   delay_cnt, delay_cnt_next;
  cnt_t   cycle_cnt;
  stamp_t first_at, first_at_next;
  stamp_t timely_at, timely_at_next;
  stamp_t latest_at, latest_at_next;
  act_t   action;
  logic   overran;
  logic   armed;
  logic   over;
  stamp_t now;

  cds_deadline_calc u_calc (
    .start_sec     (item.start_sec),
    .start_nsec    (item.start_nsec),
    .limit_sec     (limit_sec),
    .limit_nsec    (limit_nsec),
    .deadline_sec  (deadline_sec_next),
    .deadline_nsec (deadline_nsec_next)
  );

  assign now   = '{sec: item.now_sec, nsec: item.now_nsec};
  // A zero deadline (after reset) means nothing to check yet.
  assign armed = (deadline_sec != '0) || (deadline_nsec != '0);
  assign over  = armed && ((item.stop_sec > deadline_sec) ||
                 ((item.stop_sec == deadline_sec) && (item.stop_nsec > deadline_nsec)));

  always_comb begin
    delayed_next   = delayed;
    timely_next    = timely;
    delay_cnt_next = delay_cnt;
    first_at_next  = first_at;
    timely_at_next = timely_at;
    latest_at_next = latest_at;
    if (over) begin
      if (!delayed) begin
        delayed_next  = 1'b1;
        timely_next   = 1'b0;
        first_at_next = now;
      end
      delay_cnt_next = delay_cnt + cnt_t'(1);
      latest_at_next = now;
    end else if (armed && !timely) begin
      timely_next    = 1'b1;
      timely_at_next = now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadline_sec  <= '0;
      deadline_nsec <= '0;
      delayed       <= 1'b0;
      timely        <= 1'b0;
      delay_cnt     <= '0;
      cycle_cnt     <= '0;
      first_at      <= '0;
      timely_at     <= '0;
      latest_at     <= '0;
      action        <= '0;
      overran       <= 1'b0;
    end else if (step) begin
      deadline_sec  <= deadline_sec_next;
      deadline_nsec <= deadline_nsec_next;
      delayed       <= delayed_next;
      timely        <= timely_next;
      delay_cnt     <= delay_cnt_next;
      cycle_cnt     <= cycle_cnt + cnt_t'(1);
      first_at      <= first_at_next;
      timely_at     <= timely_at_next;
      latest_at     <= latest_at_next;
      action        <= over ? overrun_action : '0;
      overran       <= over;
    end
  end

  // State registers double as the result register: both move only on step.
  assign res = '{action: action, overran: overran, delayed_flag: delayed,
                 timely_flag: timely, delays_seen: delay_cnt, cycles_seen: cycle_cnt,
                 delayed_at: first_at, timely_at: timely_at, last_overrun: latest_at};
endmodule

// ===== sv/cycle_deadline_supervisor_core.sv =====
// Channel   Dir  Handshake     Word
// report    in   valid/ready   start, stop offsets and current time of one task cycle
// result    out  valid/ready   action, flags, counters and timestamps after that cycle
// cfg       in   cfg_we        limit seconds, limit nanoseconds, overrun action
//
// Two stages: an input register, then the supervision state and result register.
// Result is registered; one word per cycle sustained while result.ready stays high.
// Reset (synchronous, rst high) clears all state, the limits and both valid bits.
// A stalled result holds the state; the input register still fills behind it.
// Depends on cds_pkg, cds_if, cds_monitor, assert_macros.svh.
module cycle_deadline_supervisor_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  cds_pkg::cfg_data_t cfg_data,
  cds_report_if.sink         report,
  cds_result_if.source       result
);
  import cds_pkg::*;
  `include "assert_macros.svh"

  sec_t    limit_sec;
  nsec_t   limit_nsec;
  act_t    overrun_action;
  logic    in_valid;
  report_t in_item;
  logic    out_valid;
  logic    advance;
  logic    step;
  logic    accept;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_sec      <= '0;
      limit_nsec     <= '0;
      overrun_action <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_LIMIT_SEC:  limit_sec      <= cfg_data[SecW-1:0];
        REG_LIMIT_NSEC: limit_nsec     <= cfg_data[NsecW-1:0];
        REG_ACTION:     overrun_action <= cfg_data[ActW-1:0];
        default: ;
      endcase
    end
  end

  assign advance      = !out_valid || result.ready;
  assign step         = in_valid && advance;
  assign report.ready = !in_valid || advance;
  assign accept       = report.valid && report.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= in_valid;
      end
      if (accept) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= '{start_sec: report.start_sec, start_nsec: report.start_nsec,
                   stop_sec: report.stop_sec, stop_nsec: report.stop_nsec,
                   now_sec: report.now_sec, now_nsec: report.now_nsec};
    end
  end

  cds_monitor u_monitor (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .item           (in_item),
    .limit_sec      (limit_sec),
    .limit_nsec     (limit_nsec),
    .overrun_action (overrun_action),
    .res            (res)
  );

  assign result.valid             = out_valid;
  assign result.action            = res.action;
  assign result.overran           = res.overran;
  assign result.delayed_flag      = res.delayed_flag;
  assign result.timely_flag       = res.timely_flag;
  assign result.delays_seen       = res.delays_seen;
  assign result.cycles_seen       = res.cycles_seen;
  assign result.delayed_at_sec    = res.delayed_at.sec;
  assign result.delayed_at_nsec   = res.delayed_at.nsec;
  assign result.timely_at_sec     = res.timely_at.sec;
  assign result.timely_at_nsec    = res.timely_at.nsec;
  assign result.last_overrun_sec  = res.last_overrun.sec;
  assign result.last_overrun_nsec = res.last_overrun.nsec;

  `ASSERT_IMPLIES(a_overrun_sets_delayed, clk, rst, result.overran, result.delayed_flag)
  `ASSERT_IMPLIES(a_action_only_on_overrun, clk, rst, result.action != '0, result.overran)
  `ASSERT_NEXT(a_delayed_sticky, clk, rst, result.delayed_flag, result.delayed_flag)
  `ASSERT_NEXT(a_cycle_count_steps, clk, rst, step,
               result.cycles_seen == $past(result.cycles_seen) + 32'd1)
endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for cycle_deadline_supervisor_core: random and directed cycle reports,
// results predicted in-bench and compared field by field in the order they arrive.
// Depends on cds_pkg, cds_if and the supervisor RTL.
module testbench;
  import cds_pkg::*;

  localparam int StallLimit = 3000;
  localparam int HoldCycles = 120;
  localparam int HoldAfter = 150;
  localparam logic [1:0] RegSpare = 2'd3;
  localparam nsec_t NsecAll = '1;
  localparam logic [63:0] NsPerSec64 = 64'(NsPerSec);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  cfg_data_t cfg_data = '0;

  cds_report_if report ();
  cds_result_if result ();

  cycle_deadline_supervisor_core uut (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .report(report),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the limits and of the supervision state
  sec_t   lim_sec = '0;
  nsec_t  lim_nsec = '0;
  act_t   act_code = '0;
  sec_t   dl_sec = '0;
  nsec_t  dl_nsec = '0;
  logic   is_delayed = 1'b0;
  logic   is_timely = 1'b0;
  cnt_t   n_delays = '0;
  cnt_t   n_cycles = '0;
  stamp_t first_late = '0;
  stamp_t timely_stamp = '0;
  stamp_t last_late = '0;

  report_t pending_reports[$];
  result_t expected_status[$];

  bit    idle_on = 1'b1;
  bit    report_taken = 1'b0;
  bit    hold_done = 1'b0;
  int    hold_left = 0;
  int    stall_cycles = 0;
  int    mismatches = 0;
  int    results_seen = 0;
  int    overruns_seen = 0;
  int    unchecked_cycles = 0;
  int    settings_used = 0;
  sec_t  prev_start_sec = '0;
  nsec_t prev_start_nsec = '0;

  function automatic result_t supervise_cycle(report_t w);
    result_t r;
    stamp_t now_t;
    logic late;
    logic [63:0] ns_sum, sec_sum;
    now_t.sec = w.now_sec;
    now_t.nsec = w.now_nsec;
    late = 1'b0;
    if (dl_sec != '0 || dl_nsec != '0) begin
      late = (w.stop_sec > dl_sec) || (w.stop_sec == dl_sec && w.stop_nsec > dl_nsec);
      if (late) begin
        if (!is_delayed) begin
          first_late = now_t;
          is_delayed = 1'b1;
          is_timely = 1'b0;
        end
        n_delays = n_delays + 1'b1;
        last_late = now_t;
      end else if (!is_timely) begin
        is_timely = 1'b1;
        timely_stamp = now_t;
      end
    end else begin
      unchecked_cycles++;
    end
    // next deadline: start + limit, nanosecond carry, saturate on seconds overflow
    ns_sum = 64'(w.start_nsec) + 64'(lim_nsec);
    sec_sum = 64'(w.start_sec) + 64'(lim_sec) + ns_sum / NsPerSec64;
    ns_sum = ns_sum % NsPerSec64;
    if (sec_sum > 64'(SecMax)) begin
      sec_sum = 64'(SecMax);
      ns_sum = 64'(NsecMax);
    end
    dl_sec = sec_sum[SecW-1:0];
    dl_nsec = ns_sum[NsecW-1:0];
    n_cycles = n_cycles + 1'b1;

    r.action = late ? act_code : '0;
    r.overran = late;
    r.delayed_flag = is_delayed;
    r.timely_flag = is_timely;
    r.delays_seen = n_delays;
    r.cycles_seen = n_cycles;
    r.delayed_at = first_late;
    r.timely_at = timely_stamp;
    r.last_overrun = last_late;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // report side: predict on accept, offer the next word at the falling edge
  always @(posedge clk) begin : accept_report
    report_t w;
    report_taken = 1'b0;
    if (!rst && report.valid && report.ready) begin
      report_taken = 1'b1;
      w.start_sec = report.start_sec;
      w.start_nsec = report.start_nsec;
      w.stop_sec = report.stop_sec;
      w.stop_nsec = report.stop_nsec;
      w.now_sec = report.now_sec;
      w.now_nsec = report.now_nsec;
      expected_status.push_back(supervise_cycle(w));
    end
  end

  always @(negedge clk) begin : drive_report
    report_t w;
    if (!rst && (!report.valid || report_taken)) begin
      if (pending_reports.size() != 0 && !(idle_on && $urandom_range(99) < 17)) begin
        w = pending_reports.pop_front();
        report.valid <= 1'b1;
        report.start_sec <= w.start_sec;
        report.start_nsec <= w.start_nsec;
        report.stop_sec <= w.stop_sec;
        report.stop_nsec <= w.stop_nsec;
        report.now_sec <= w.now_sec;
        report.now_nsec <= w.now_nsec;
      end else begin
        report.valid <= 1'b0;
      end
    end
  end

  // result side: one long hold-off lets the pipeline back up into the input
  always @(negedge clk) begin : drive_ready
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      result.ready <= 1'b0;
    end else begin
      result.ready <= !(idle_on && $urandom_range(99) < 17);
    end
  end

  always @(posedge clk) begin : check_result
    result_t want;
    if (!rst && result.valid && result.ready) begin
      results_seen++;
      if (expected_status.size() == 0) begin
        $error("result word with no cycle report outstanding");
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        if (want.overran) overruns_seen++;
        check_field("action", want.action, result.action);
        check_field("overran", want.overran, result.overran);
        check_field("delayed_flag", want.delayed_flag, result.delayed_flag);
        check_field("timely_flag", want.timely_flag, result.timely_flag);
        check_field("delays_seen", want.delays_seen, result.delays_seen);
        check_field("cycles_seen", want.cycles_seen, result.cycles_seen);
        check_field("delayed_at_sec", want.delayed_at.sec, result.delayed_at_sec);
        check_field("delayed_at_nsec", want.delayed_at.nsec, result.delayed_at_nsec);
        check_field("timely_at_sec", want.timely_at.sec, result.timely_at_sec);
        check_field("timely_at_nsec", want.timely_at.nsec, result.timely_at_nsec);
        check_field("last_overrun_sec", want.last_overrun.sec, result.last_overrun_sec);
        check_field("last_overrun_nsec", want.last_overrun.nsec, result.last_overrun_nsec);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (report.valid && report.ready) || (result.valid && result.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles == StallLimit) begin
      $display("no handshake on either channel for %0d cycles", StallLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, cfg_data_t data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LIMIT_SEC: lim_sec = data[SecW-1:0];
      REG_LIMIT_NSEC: lim_nsec = data[NsecW-1:0];
      REG_ACTION: act_code = data[ActW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(sec_t s, nsec_t ns, act_t a);
    write_reg(REG_LIMIT_SEC, cfg_data_t'(s));
    write_reg(REG_LIMIT_NSEC, cfg_data_t'(ns));
    write_reg(REG_ACTION, cfg_data_t'(a));
    settings_used++;
  endtask

  // wait until every report is out and answered, then give the pipe a few cycles
  task automatic settle();
    while (pending_reports.size() != 0 || report.valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_report(sec_t s_s, nsec_t s_ns, sec_t p_s, nsec_t p_ns,
                              abs_sec_t n_s, nsec_t n_ns);
    report_t w;
    w.start_sec = s_s;
    w.start_nsec = s_ns;
    w.stop_sec = p_s;
    w.stop_nsec = p_ns;
    w.now_sec = n_s;
    w.now_nsec = n_ns;
    pending_reports.push_back(w);
    prev_start_sec = s_s;
    prev_start_nsec = s_ns;
  endtask

  // stop offsets cluster around the deadline the previous start sets up
  task automatic queue_random(int n);
    logic [63:0] t_ns, t_sec;
    sec_t s_s, p_s;
    nsec_t s_ns, p_ns;
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      t_ns = 64'(prev_start_nsec) + 64'(lim_nsec);
      t_sec = 64'(prev_start_sec) + 64'(lim_sec) + t_ns / NsPerSec64;
      t_ns = t_ns % NsPerSec64;
      if (t_sec > 64'(SecMax)) begin
        t_sec = 64'(SecMax);
        t_ns = 64'(NsecMax);
      end
      r = $urandom_range(99);
      if (r < 80) begin
        s_s = sec_t'($urandom_range(0, 1000));
        s_ns = nsec_t'($urandom_range(0, 999999999));
      end else if (r < 90) begin
        s_s = sec_t'($urandom());
        s_ns = nsec_t'($urandom());
      end else begin
        s_s = $urandom_range(1) ? SecMax : '0;
        s_ns = $urandom_range(1) ? NsecAll : '0;
      end
      r = $urandom_range(99);
      if (r < 35) begin
        p_s = t_sec[SecW-1:0];
        p_ns = t_ns[NsecW-1:0];
      end else if (r < 60) begin
        p_s = t_sec[SecW-1:0];
        p_ns = nsec_t'(t_ns + $urandom_range(0, 2000) - 1000);
      end else if (r < 80) begin
        p_s = sec_t'(t_sec + $urandom_range(0, 2) - 1);
        p_ns = nsec_t'($urandom_range(0, 999999999));
      end else begin
        p_s = sec_t'($urandom());
        p_ns = nsec_t'($urandom());
      end
      queue_report(s_s, s_ns, p_s, p_ns, abs_sec_t'($urandom()), nsec_t'($urandom()));
    end
  endtask

  initial begin
    report.valid = 1'b0;
    report.start_sec = '0;
    report.start_nsec = '0;
    report.stop_sec = '0;
    report.stop_nsec = '0;
    report.now_sec = '0;
    report.now_nsec = '0;
    result.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // first report after reset has no deadline; equal stop meets, carry and saturation
    set_limits(1, 500000000, 3);
    queue_report(0, 0, SecMax, NsecAll, '0, '0);
    queue_report(0, 0, 1, 500000000, 1, 1);
    queue_report(10, 999999999, 1, 500000001, 2, 2);
    queue_report(SecMax, 0, 12, 499999999, 3, 3);
    queue_report(SecMax, NsecAll, SecMax, NsecMax, 4, 4);
    queue_report(0, 0, SecMax, NsecAll, '1, NsecAll);
    queue_report(0, NsecAll, 2, 0, 5, 5);
    queue_report(0, 0, 1, 999999999, 6, 6);
    queue_report(5, 0, 0, 0, 7, 7);
    settle();

    // zero limits let a zero start clear the deadline; spare index must not land
    set_limits(0, 0, 1);
    write_reg(RegSpare, '1);
    queue_report(0, 0, 0, 1, 8, 8);
    queue_report(3, 7, SecMax, NsecAll, 9, 9);
    queue_report(0, 0, 3, 8, 10, 10);
    settle();

    // out-of-range nanoseconds: two carries into the seconds
    set_limits(0, NsecAll, 2);
    queue_report(5, NsecAll, 0, 0, 11, 11);
    queue_report(0, 0, 7, 147483647, 12, 12);
    queue_report(1, 1, 1, 73741823, 13, 13);
    settle();

    // largest limit: exact fit, then saturation; overrun with action zero
    set_limits(SecMax, NsecMax, 0);
    queue_report(0, 0, 0, 0, 14, 14);
    queue_report(1, 0, SecMax, NsecMax, 15, 15);
    queue_report(0, 1, SecMax, NsecAll, 16, 16);
    queue_report(0, 0, 0, 0, '1, NsecAll);
    settle();

    idle_on = 1'b0;
    set_limits(0, 1000, 1);
    queue_random(200);
    settle();

    idle_on = 1'b1;
    set_limits(3, 250000000, 2);
    queue_random(200);
    settle();

    set_limits(sec_t'($urandom()), nsec_t'($urandom()), act_t'($urandom()));
    queue_random(200);
    settle();

    set_limits(0, 0, 0);
    queue_random(200);
    settle();

    set_limits(SecMax, NsecMax, 1);
    queue_random(150);
    settle();

    set_limits(sec_t'($urandom_range(0, 5)), nsec_t'($urandom_range(0, 999999999)),
               act_t'($urandom_range(0, 3)));
    queue_random(250);
    settle();
    repeat (8) @(posedge clk);

    if (expected_status.size() != 0) mismatches++;
    $display("Checked %0d supervision results over %0d limit settings.",
             results_seen, settings_used);
    $display("Overruns: %0d, cycles with no deadline armed: %0d, mismatches: %0d.",
             overruns_seen, unchecked_cycles, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
